>>> design/nht_pkg.sv
package nht_pkg;

  localparam int NODE_SLOTS_DEF = 16;

  localparam int KIND_W  = 3;
  localparam int INDEX_W = 4;
  localparam int CNT_W   = 8;
  localparam int HLTH_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_SUCCESS   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SERV_ERR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CONN_FAIL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd4;

  // health codes
  localparam logic [HLTH_W-1:0] H_ACTIVE = 2'd0;
  localparam logic [HLTH_W-1:0] H_QUAR   = 2'd1;
  localparam logic [HLTH_W-1:0] H_DOWN   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCC_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISABLE  = 2'd2;

  typedef struct packed {
    logic              used;
    logic [HLTH_W-1:0] health;
    logic [CNT_W-1:0]  errors;
    logic [CNT_W-1:0]  successes;
  } slot_t;

  typedef struct packed {
    logic [CNT_W-1:0] err_thr;
    logic [CNT_W-1:0] succ_thr;
    logic             disabled;
  } cfg_t;

  function automatic logic [CNT_W-1:0] eff_thr(input logic [CNT_W-1:0] t);
    eff_thr = (t == '0) ? CNT_W'(1) : t;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

>>> design/nht_slot_table.sv
module nht_slot_table #(
  parameter int NODE_SLOTS = nht_pkg::NODE_SLOTS_DEF,
  parameter int IDX_W      = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IDX_W-1:0]     rd_idx,
  output nht_pkg::slot_t       rd_entry,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  nht_pkg::slot_t       wr_entry
);

  logic [NODE_SLOTS-1:0]          used_r;
  logic [nht_pkg::HLTH_W-1:0]     health_r [NODE_SLOTS];
  logic [nht_pkg::CNT_W-1:0]      errors_r [NODE_SLOTS];
  logic [nht_pkg::CNT_W-1:0]      succ_r   [NODE_SLOTS];

  // present flags clear at reset, the rest is written by an add before use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr_en) begin
      used_r[wr_idx] <= wr_entry.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      health_r[wr_idx] <= wr_entry.health;
      errors_r[wr_idx] <= wr_entry.errors;
      succ_r[wr_idx]   <= wr_entry.successes;
    end
  end

  always_comb begin
    rd_entry.used      = used_r[rd_idx];
    rd_entry.health    = health_r[rd_idx];
    rd_entry.errors    = errors_r[rd_idx];
    rd_entry.successes = succ_r[rd_idx];
  end

endmodule

>>> design/nht_update.sv
module nht_update (
  input  logic [nht_pkg::KIND_W-1:0] kind,
  input  logic                       in_range,
  input  nht_pkg::cfg_t              cfg,
  input  nht_pkg::slot_t             cur,
  output logic                       wr_en,
  output nht_pkg::slot_t             nxt,
  output nht_pkg::slot_t             result
);

  logic [nht_pkg::CNT_W-1:0] et;
  logic [nht_pkg::CNT_W-1:0] st;
  logic [nht_pkg::CNT_W-1:0] succ_inc;
  logic [nht_pkg::CNT_W-1:0] err_inc;
  logic                      report_ok;

  assign et        = nht_pkg::eff_thr(cfg.err_thr);
  assign st        = nht_pkg::eff_thr(cfg.succ_thr);
  assign succ_inc  = nht_pkg::sat_inc(cur.successes);
  assign err_inc   = nht_pkg::sat_inc(cur.errors);
  assign report_ok = !cfg.disabled && cur.used;
  assign wr_en     = in_range;

  always_comb begin
    nxt = cur;
    case (kind)
      nht_pkg::KIND_ADD: begin
        if (!cur.used) begin
          nxt.used      = 1'b1;
          nxt.health    = nht_pkg::H_ACTIVE;
          nxt.errors    = '0;
          nxt.successes = st;
        end
      end
      nht_pkg::KIND_REMOVE: begin
        nxt.used = 1'b0;
      end
      nht_pkg::KIND_SUCCESS: begin
        if (report_ok) begin
          nxt.errors = '0;
          if (cur.health == nht_pkg::H_DOWN) begin
            nxt.health    = nht_pkg::H_QUAR;
            nxt.successes = nht_pkg::CNT_W'(1);
          end else if (cur.health == nht_pkg::H_QUAR) begin
            if (succ_inc >= st) begin
              nxt.health    = nht_pkg::H_ACTIVE;
              nxt.successes = st;
            end else begin
              nxt.successes = succ_inc;
            end
          end else begin
            nxt.successes = st;
          end
        end
      end
      nht_pkg::KIND_SERV_ERR: begin
        if (report_ok) begin
          nxt.errors    = err_inc;
          nxt.successes = '0;
          if (err_inc >= et) begin
            nxt.health = nht_pkg::H_DOWN;
          end
        end
      end
      nht_pkg::KIND_CONN_FAIL: begin
        if (report_ok) begin
          nxt.health    = nht_pkg::H_DOWN;
          nxt.errors    = et;
          nxt.successes = '0;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // empty or out-of-range slot reads as all zero
  always_comb begin
    if (in_range && nxt.used) begin
      result = nxt;
    end else begin
      result = '0;
    end
  end

endmodule

>>> design/node_health_tracker_unit.sv
// Node health tracker: a table of NODE_SLOTS node slots, each with a present
// flag, a health state (active, quarantined, down) and saturating counts of
// consecutive server errors and successes. Each request adds or removes a
// node or reports success, server error or connection failure for it, and
// returns exactly one result with the slot's status after the update.
// Throughput is one request per clock while out_ready holds; the input
// register and the result register enclose the single read-modify-write
// of the flop-based slot table that sets the rate. The output register
// lets the next request enter while a result waits for out_ready. The
// user writes thresholds and the disable bit through the cfg port only
// while no request is in flight; the block does not enforce this. A
// threshold of 0 acts as 1. No clearing pass is needed after reset.
module node_health_tracker_unit #(
  parameter int NODE_SLOTS = nht_pkg::NODE_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [nht_pkg::KIND_W-1:0]       in_kind,
  input  logic [nht_pkg::INDEX_W-1:0]      in_node_index,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_present,
  output logic [nht_pkg::HLTH_W-1:0]       out_health,
  output logic [nht_pkg::CNT_W-1:0]        out_error_count,
  output logic [nht_pkg::CNT_W-1:0]        out_success_count,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [nht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nht_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

  localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  // wide enough for the node index and for NODE_SLOTS itself
  localparam int EXT_W = ((IDX_W > nht_pkg::INDEX_W) ? IDX_W : nht_pkg::INDEX_W) + 1;

  // configuration registers
  nht_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.err_thr  <= nht_pkg::CNT_W'(1);
      cfg_r.succ_thr <= nht_pkg::CNT_W'(1);
      cfg_r.disabled <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nht_pkg::CFG_ERR_THR:  cfg_r.err_thr  <= cfg_wr_data;
        nht_pkg::CFG_SUCC_THR: cfg_r.succ_thr <= cfg_wr_data;
        nht_pkg::CFG_DISABLE:  cfg_r.disabled <= cfg_wr_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  logic                           s1_valid_r;
  logic [nht_pkg::KIND_W-1:0]     s1_kind_r;
  logic [nht_pkg::INDEX_W-1:0]    s1_index_r;
  logic                           s2_load;

  // stage 1 moves on when the result register is free or being drained
  assign s2_load  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s2_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r  <= in_kind;
      s1_index_r <= in_node_index;
    end
  end

  // slot lookup
  logic [EXT_W-1:0] idx_ext;
  logic             in_range;
  logic [IDX_W-1:0] slot_sel;

  assign idx_ext  = EXT_W'(s1_index_r);
  assign in_range = idx_ext < EXT_W'(NODE_SLOTS);
  assign slot_sel = idx_ext[IDX_W-1:0];

  nht_pkg::slot_t cur_entry;
  nht_pkg::slot_t nxt_entry;
  nht_pkg::slot_t res_entry;
  logic           upd_wr_en;

  nht_slot_table #(
    .NODE_SLOTS (NODE_SLOTS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (slot_sel),
    .rd_entry (cur_entry),
    .wr_en    (upd_wr_en && s2_load),
    .wr_idx   (slot_sel),
    .wr_entry (nxt_entry)
  );

  nht_update u_update (
    .kind     (s1_kind_r),
    .in_range (in_range),
    .cfg      (cfg_r),
    .cur      (cur_entry),
    .wr_en    (upd_wr_en),
    .nxt      (nxt_entry),
    .result   (res_entry)
  );

  // result register
  logic           out_valid_r;
  logic           out_valid_nxt;
  nht_pkg::slot_t out_res_r;

  assign out_valid_nxt = s2_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_res_r <= res_entry;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_present       = out_res_r.used;
  assign out_health        = out_res_r.health;
  assign out_error_count   = out_res_r.errors;
  assign out_success_count = out_res_r.successes;

`ifndef SYNTH
  // an empty slot always reports all-zero status
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_present) |->
      (out_health == '0 && out_error_count == '0 && out_success_count == '0))
    else $error("empty slot result carries nonzero fields");

  // a connection failure on a live node shows it down
  a_conn_down: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && in_range && s1_kind_r == nht_pkg::KIND_CONN_FAIL &&
     cur_entry.used && !cfg_r.disabled) |=>
      (out_valid && out_present && out_health == nht_pkg::H_DOWN))
    else $error("connection failure did not mark node down");

  // an add always leaves the slot present
  a_add_present: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && in_range && s1_kind_r == nht_pkg::KIND_ADD) |=>
      (out_valid && out_present))
    else $error("add did not leave slot present");

  // both stages full and stalled must hold off new requests
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid && !out_ready) |-> !in_ready)
    else $error("request accepted with pipeline full");
`endif

endmodule

>>> sim/node_health_tracker_unit_tb.sv
`timescale 1ns / 100ps

module node_health_tracker_unit_tb;

  localparam int NODES        = nht_pkg::NODE_SLOTS_DEF;
  localparam int STALL_LIMIT  = 1000;   // cycles with no handshake on either channel
  localparam int SETTLE_CYCLES = 6;     // pipeline is two deep, leave some margin

  // status of one slot as the block reports it
  typedef struct packed {
    logic                       present;
    logic [nht_pkg::HLTH_W-1:0] health;
    logic [nht_pkg::CNT_W-1:0]  errors;
    logic [nht_pkg::CNT_W-1:0]  successes;
  } node_status_t;

  // predicts the slot table and checks every returned status in order
  class health_scoreboard;
    nht_pkg::slot_t            slots [NODES];
    logic [nht_pkg::CNT_W-1:0] err_limit;
    logic [nht_pkg::CNT_W-1:0] succ_limit;
    logic                      reports_off;
    node_status_t              status_q [$];
    int                        mismatches;
    int                        results_seen;

    function new();
      foreach (slots[i]) slots[i] = '0;
      err_limit    = 8'd1;
      succ_limit   = 8'd1;
      reports_off  = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_config(logic [nht_pkg::CNT_W-1:0] et, logic [nht_pkg::CNT_W-1:0] st,
                             logic dis);
      err_limit   = et;
      succ_limit  = st;
      reports_off = dis;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // apply one accepted request to the predicted table
    function void note_request(logic [nht_pkg::KIND_W-1:0] kind,
                               logic [nht_pkg::INDEX_W-1:0] idx);
      logic [nht_pkg::CNT_W-1:0] et;
      logic [nht_pkg::CNT_W-1:0] st;
      node_status_t              want;
      // a zero threshold behaves as one
      et = (err_limit == '0) ? 8'd1 : err_limit;
      st = (succ_limit == '0) ? 8'd1 : succ_limit;
      case (kind)
        nht_pkg::KIND_ADD: begin
          if (!slots[idx].used) slots[idx] = '{1'b1, nht_pkg::H_ACTIVE, 8'd0, st};
        end
        nht_pkg::KIND_REMOVE: slots[idx].used = 1'b0;
        nht_pkg::KIND_SUCCESS, nht_pkg::KIND_SERV_ERR, nht_pkg::KIND_CONN_FAIL: begin
          // reports only touch a present slot while reports are enabled
          if (!reports_off && slots[idx].used) begin
            if (kind == nht_pkg::KIND_SUCCESS) begin
              slots[idx].errors = 8'd0;
              if (slots[idx].health == nht_pkg::H_DOWN) begin
                slots[idx].health    = nht_pkg::H_QUAR;
                slots[idx].successes = 8'd1;
              end else if (slots[idx].health == nht_pkg::H_QUAR) begin
                if (slots[idx].successes != 8'hff)
                  slots[idx].successes = slots[idx].successes + 8'd1;
                if (slots[idx].successes >= st) begin
                  slots[idx].health    = nht_pkg::H_ACTIVE;
                  slots[idx].successes = st;
                end
              end else begin
                slots[idx].successes = st;
              end
            end else if (kind == nht_pkg::KIND_SERV_ERR) begin
              if (slots[idx].errors != 8'hff)
                slots[idx].errors = slots[idx].errors + 8'd1;
              slots[idx].successes = 8'd0;
              if (slots[idx].errors >= et) slots[idx].health = nht_pkg::H_DOWN;
            end else begin
              slots[idx].health    = nht_pkg::H_DOWN;
              slots[idx].errors    = et;
              slots[idx].successes = 8'd0;
            end
          end
        end
        default: ;  // unknown kinds leave the table alone
      endcase
      want = '0;
      if (slots[idx].used)
        want = '{1'b1, slots[idx].health, slots[idx].errors, slots[idx].successes};
      status_q.insert(status_q.size(), want);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task check_status(logic present, logic [nht_pkg::HLTH_W-1:0] health,
                      logic [nht_pkg::CNT_W-1:0] errors,
                      logic [nht_pkg::CNT_W-1:0] successes);
      node_status_t want;
      if (status_q.size() == 0) begin
        report_mismatch("status returned with no request outstanding");
      end else begin
        want = status_q.pop_front();
        if (present !== want.present)
          report_mismatch($sformatf("present got %0d want %0d", present, want.present));
        if (health !== want.health)
          report_mismatch($sformatf("health got %0d want %0d", health, want.health));
        if (errors !== want.errors)
          report_mismatch($sformatf("error_count got %0d want %0d", errors, want.errors));
        if (successes !== want.successes)
          report_mismatch($sformatf("success_count got %0d want %0d",
                                    successes, want.successes));
      end
      results_seen++;
    endtask
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                           clk;
  logic                           rst_n         = 1'b0;
  logic                           in_valid      = 1'b0;
  logic                           in_ready;
  logic [nht_pkg::KIND_W-1:0]     in_kind       = '0;
  logic [nht_pkg::INDEX_W-1:0]    in_node_index = '0;
  logic                           out_valid;
  logic                           out_ready     = 1'b0;
  logic                           out_present;
  logic [nht_pkg::HLTH_W-1:0]     out_health;
  logic [nht_pkg::CNT_W-1:0]      out_error_count;
  logic [nht_pkg::CNT_W-1:0]      out_success_count;
  logic                           cfg_wr_en     = 1'b0;
  logic [nht_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [nht_pkg::CFG_DATA_W-1:0] cfg_wr_data   = '0;

  health_scoreboard sb;

  int                          send_idle_pct = 0;
  int                          recv_idle_pct = 0;
  int                          sent_total    = 0;
  int                          quiet_cycles  = 0;
  logic [NODES-1:0]            live_map      = '0;  // stimulus-side view of live slots
  logic [nht_pkg::INDEX_W-1:0] hot_base      = '0;

  node_health_tracker_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_node_index     (in_node_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_present       (out_present),
    .out_health        (out_health),
    .out_error_count   (out_error_count),
    .out_success_count (out_success_count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // handshake monitor: feed the predictor, check results, track idle time
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_kind, in_node_index);
      if (out_valid && out_ready)
        sb.check_status(out_present, out_health, out_error_count, out_success_count);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: nothing moving for too long ends the run
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("[node_health_tracker_unit] ERROR");
    $finish;
  end

  // one request: optional idle gap, then hold valid until accepted
  task automatic send_request(input logic [nht_pkg::KIND_W-1:0] k,
                              input logic [nht_pkg::INDEX_W-1:0] idx);
    // idle pattern moves through three regimes over the run
    if (sent_total < 530) begin
      send_idle_pct = 31;
      recv_idle_pct = 46;
    end else if (sent_total < 1060) begin
      send_idle_pct = 46;
      recv_idle_pct = 31;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_node_index <= idx;
    do @(posedge clk); while (!in_ready);
    if (k == nht_pkg::KIND_ADD) live_map[idx] = 1'b1;
    else if (k == nht_pkg::KIND_REMOVE) live_map[idx] = 1'b0;
    sent_total++;
  endtask

  // stop sending and wait for every outstanding status
  task automatic drain_requests();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers back to back, only while idle
  task automatic apply_settings(input logic [nht_pkg::CNT_W-1:0] et,
                                input logic [nht_pkg::CNT_W-1:0] st,
                                input logic dis);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= nht_pkg::CFG_ERR_THR;
    cfg_wr_data <= et;
    @(posedge clk);
    cfg_index   <= nht_pkg::CFG_SUCC_THR;
    cfg_wr_data <= st;
    @(posedge clk);
    cfg_index   <= nht_pkg::CFG_DISABLE;
    cfg_wr_data <= {7'd0, dis};
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_config(et, st, dis);
  endtask

  // random traffic: mostly reports on a few busy slots that hold nodes, some noise
  task automatic run_random(input int target);
    int                          n;
    int                          r;
    logic [nht_pkg::INDEX_W-1:0] idx;
    logic [nht_pkg::KIND_W-1:0]  k;
    n        = 0;
    hot_base = nht_pkg::INDEX_W'($urandom_range(0, NODES - 1));
    while (n < target) begin
      if ($urandom_range(0, 9) < 7) idx = hot_base + nht_pkg::INDEX_W'($urandom_range(0, 3));
      else idx = nht_pkg::INDEX_W'($urandom_range(0, NODES - 1));
      r = $urandom_range(0, 99);
      if (!live_map[idx]) begin
        if (r < 75) k = nht_pkg::KIND_ADD;
        else if (r < 90) k = nht_pkg::KIND_W'($urandom_range(0, 2));  // report to empty slot
        else if (r < 95) k = nht_pkg::KIND_REMOVE;
        else k = nht_pkg::KIND_W'($urandom_range(5, 7));
      end else begin
        if (r < 45) k = nht_pkg::KIND_SUCCESS;
        else if (r < 75) k = nht_pkg::KIND_SERV_ERR;
        else if (r < 83) k = nht_pkg::KIND_CONN_FAIL;
        else if (r < 88) k = nht_pkg::KIND_ADD;
        else if (r < 94) k = nht_pkg::KIND_REMOVE;
        else k = nht_pkg::KIND_W'($urandom_range(5, 7));
      end
      send_request(k, idx);
      n++;
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset thresholds of one, every kind, empty slots, unknown kinds
    send_request(nht_pkg::KIND_SUCCESS, 4'd0);     // report to empty slot
    send_request(3'd5, 4'd0);
    send_request(3'd6, 4'd0);
    send_request(3'd7, 4'd0);
    send_request(nht_pkg::KIND_ADD, 4'd0);
    send_request(nht_pkg::KIND_ADD, 4'd0);         // add to a present slot
    send_request(nht_pkg::KIND_SUCCESS, 4'd0);     // active stays active
    send_request(nht_pkg::KIND_SERV_ERR, 4'd0);    // reaches threshold, down
    send_request(nht_pkg::KIND_SUCCESS, 4'd0);     // down to quarantined
    send_request(nht_pkg::KIND_SUCCESS, 4'd0);     // quarantined back to active
    send_request(nht_pkg::KIND_CONN_FAIL, 4'd0);
    send_request(nht_pkg::KIND_REMOVE, 4'd0);
    send_request(nht_pkg::KIND_SERV_ERR, 4'd0);    // report after removal
    send_request(nht_pkg::KIND_REMOVE, 4'd15);     // remove empty slot
    send_request(nht_pkg::KIND_ADD, 4'd15);
    send_request(nht_pkg::KIND_SERV_ERR, 4'd15);
    send_request(nht_pkg::KIND_CONN_FAIL, 4'd15);
    send_request(3'd7, 4'd15);
    send_request(nht_pkg::KIND_REMOVE, 4'd15);
    send_request(nht_pkg::KIND_ADD, 4'd10);
    send_request(nht_pkg::KIND_SUCCESS, 4'd10);
    run_random(130);
    drain_requests();

    // zero thresholds act as one
    apply_settings(8'd0, 8'd0, 1'b0);
    run_random(100);
    drain_requests();

    apply_settings(8'd3, 8'd2, 1'b0);
    run_random(200);
    drain_requests();

    // top thresholds: drive both counters into saturation
    apply_settings(8'd255, 8'd255, 1'b0);
    send_request(nht_pkg::KIND_REMOVE, 4'd9);
    send_request(nht_pkg::KIND_ADD, 4'd9);
    repeat (260) send_request(nht_pkg::KIND_SERV_ERR, 4'd9);
    send_request(nht_pkg::KIND_SUCCESS, 4'd9);
    repeat (260) send_request(nht_pkg::KIND_SUCCESS, 4'd9);
    send_request(nht_pkg::KIND_CONN_FAIL, 4'd9);
    run_random(65);
    drain_requests();

    // reports ignored, add and remove still act
    apply_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 1'b1);
    run_random(80);
    drain_requests();

    apply_settings(8'd1, 8'd255, 1'b0);
    run_random(100);
    drain_requests();

    apply_settings(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)), 1'b0);
    run_random(200);
    drain_requests();

    apply_settings(8'd2, 8'd5, 1'b0);
    run_random(180);
    drain_requests();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[node_health_tracker_unit] OK");
    else
      $display("[node_health_tracker_unit] ERROR");
    $finish;
  end

endmodule
